// ----- src/prtd_pkg.sv -----
// Shared types and constants for the PackBits row-trim decoder.
`default_nettype none
package prtd_pkg;

	localparam int MAX_DIM   = 1024;
	localparam int DIM_W     = $clog2(MAX_DIM);
	localparam int POS_W     = DIM_W + 1;
	localparam int PIX_W     = 2 * DIM_W;
	localparam int DIV_STEPS = POS_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_PADDING = 2'd2;

	typedef struct packed {
		logic [7:0] src_byte;
		logic       last_byte;
	} src_word_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic [7:0] run_length;
		logic       end_of_image;
	} run_word_t;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic             row_padding;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div_step;
		logic update;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_data;
		logic fast;
		logic last;
		logic div_last;
		logic keep_nz;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- src/prtd_ctrl.sv -----
// Controller state machine: sequences parse and, as each word needs, divide, update and emit.
`default_nettype none
module prtd_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  src_valid,
	output logic                       src_ready,
	input  wire logic                  out_free,
	input  wire prtd_pkg::dp_status_t  status,
	output prtd_pkg::ctrl_cmd_t        cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SETUP  = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign src_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (src_valid) begin
					cmd.load = 1'b1;
					state_nx = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				if (!status.is_data) begin
					state_nx = status.last ? S_EMIT : S_IDLE;
				end else if (status.fast) begin
					state_nx = S_UPDATE;
				end else begin
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nx = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = (status.last || status.keep_nz) ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
`default_nettype wire

// ----- src/prtd_dpath.sv -----
// Datapath: parse state, row position divider, pad removal and clipping.
`default_nettype none
module prtd_dpath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire prtd_pkg::cfg_t        cfg,
	input  wire prtd_pkg::src_word_t   src,
	input  wire prtd_pkg::ctrl_cmd_t   cmd,
	output prtd_pkg::dp_status_t       status,
	output prtd_pkg::run_word_t        res
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_VALUE   = 2'd1;
	localparam logic [1:0] PH_LITERAL = 2'd2;

	localparam int DIM_W = prtd_pkg::DIM_W;
	localparam int POS_W = prtd_pkg::POS_W;
	localparam int PIX_W = prtd_pkg::PIX_W;
	localparam int STEP_W = prtd_pkg::STEP_W;

	logic [7:0]        byte_q;
	logic              last_q;
	logic [1:0]        phase_q;
	logic [7:0]        lit_q;
	logic [7:0]        rep_q;
	logic [DIM_W-1:0]  col_q;
	logic [PIX_W-1:0]  pix_q;
	logic [PIX_W-1:0]  limit_q;
	logic [7:0]        n_q;
	logic [POS_W-1:0]  acc_q;
	logic [POS_W-1:0]  dd_q;
	logic [POS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	prtd_pkg::run_word_t res_q;

	logic             is_data;
	logic [POS_W-1:0] d;
	logic [DIM_W-1:0] c_eff;
	logic [7:0]       n;
	logic [POS_W-1:0] t;
	logic             fast;
	logic             t_ge;
	logic [7:0]       lit_nx;

	logic [POS_W:0]   trial;
	logic             trial_ge;
	logic [POS_W:0]   trial_sub;

	logic [7:0]       pads;
	logic [7:0]       kb;
	logic [PIX_W-1:0] room;
	logic [7:0]       kept;

	assign is_data = (phase_q == PH_VALUE) || (phase_q == PH_LITERAL);

	always_comb begin
		d = cfg.row_padding ? ({1'b0, cfg.image_width} + POS_W'(1))
		                    : {1'b0, cfg.image_width};
		if (col_q >= cfg.image_width) begin
			c_eff = cfg.row_padding ? cfg.image_width : (cfg.image_width - DIM_W'(1));
		end else begin
			c_eff = col_q;
		end
		n      = (phase_q == PH_VALUE) ? rep_q : 8'd1;
		t      = {1'b0, c_eff} + POS_W'(n);
		fast   = (d == '0) || ({1'b0, t} < {d, 1'b0});
		t_ge   = (t >= d);
		lit_nx = (lit_q != 8'd0) ? (lit_q - 8'd1) : 8'd0;
	end

	always_comb begin
		trial     = {acc_q, dd_q[POS_W-1]};
		trial_ge  = (trial >= {1'b0, dvs_q});
		trial_sub = trial - {1'b0, dvs_q};
	end

	always_comb begin
		pads = cfg.row_padding ? dd_q[7:0] : 8'd0;
		kb   = n_q - pads;
		room = (pix_q < limit_q) ? (limit_q - pix_q) : '0;
		kept = (PIX_W'(kb) < room) ? kb : room[7:0];
	end

	always_comb begin
		status.is_data  = is_data;
		status.fast     = fast;
		status.last     = last_q;
		status.div_last = (cnt_q == STEP_W'(1));
		status.keep_nz  = (kept != 8'd0);
	end

	assign res = res_q;

	always_ff @(posedge clk) begin
		limit_q <= cfg.image_width * cfg.image_height;
		if (cmd.load) begin
			byte_q <= src.src_byte;
			last_q <= src.last_byte;
		end
		if (cmd.setup) begin
			n_q   <= n;
			dvs_q <= d;
			if (!is_data) begin
				res_q.pixel_value  <= 8'd0;
				res_q.run_length   <= 8'd0;
				res_q.end_of_image <= last_q;
			end
			if (d == '0) begin
				acc_q <= '0;
				dd_q  <= '0;
			end else if (fast) begin
				acc_q <= t_ge ? (t - d) : t;
				dd_q  <= POS_W'(t_ge);
			end else begin
				acc_q <= '0;
				dd_q  <= t;
			end
		end else if (cmd.div_step) begin
			acc_q <= trial_ge ? trial_sub[POS_W-1:0] : trial[POS_W-1:0];
			dd_q  <= {dd_q[POS_W-2:0], trial_ge};
		end
		if (cmd.update) begin
			res_q.pixel_value  <= byte_q;
			res_q.run_length   <= kept;
			res_q.end_of_image <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			lit_q   <= '0;
			rep_q   <= '0;
			col_q   <= '0;
			pix_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.setup) begin
				cnt_q <= STEP_W'(prtd_pkg::DIV_STEPS);
				if (!is_data) begin
					if (last_q) begin
						phase_q <= PH_HEADER;
						lit_q   <= '0;
						rep_q   <= '0;
						col_q   <= '0;
						pix_q   <= '0;
					end else if (byte_q[7]) begin
						rep_q   <= 8'((9'd257 - {1'b0, byte_q}));
						phase_q <= PH_VALUE;
					end else begin
						lit_q   <= byte_q + 8'd1;
						phase_q <= PH_LITERAL;
					end
				end else if (phase_q == PH_VALUE) begin
					rep_q   <= '0;
					phase_q <= PH_HEADER;
				end else begin
					lit_q <= lit_nx;
					if (lit_nx == 8'd0) begin
						phase_q <= PH_HEADER;
					end
				end
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
			if (cmd.update) begin
				if (last_q) begin
					phase_q <= PH_HEADER;
					lit_q   <= '0;
					rep_q   <= '0;
					col_q   <= '0;
					pix_q   <= '0;
				end else begin
					col_q <= acc_q[DIM_W-1:0];
					pix_q <= pix_q + PIX_W'(kept);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/packbits_rle_row_trim_decoder_unit.sv -----
// Top level of the PackBits run decoder with row-pad removal and clipping.
//
//   port group   dir  handshake            payload
//   src          in   src_valid/src_ready  prtd_pkg::src_word_t
//   run          out  run_valid/run_ready  prtd_pkg::run_word_t
//   wr_*         in   wr_en                wr_index, wr_data
//
// A header byte goes through load and setup; a data byte through load, setup and
// update, and either adds emit when it hands off a run. A repeat run ending two row
// widths or more past its row start also passes the bit-serial row position divider.
// Reset restores the register defaults and the expecting-header parse state.
// While a run waits in the output register the next word is still accepted;
// the following run holds in the controller until the register frees.
`default_nettype none
module packbits_rle_row_trim_decoder_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               src_valid,
	output logic                                    src_ready,
	input  wire prtd_pkg::src_word_t                src,
	output logic                                    run_valid,
	input  wire logic                               run_ready,
	output prtd_pkg::run_word_t                     run,
	input  wire logic                               wr_en,
	input  wire logic [prtd_pkg::IDX_W-1:0]         wr_index,
	input  wire logic [prtd_pkg::DIM_W-1:0]         wr_data
);

	prtd_pkg::cfg_t       cfg_q;
	prtd_pkg::ctrl_cmd_t  cmd;
	prtd_pkg::dp_status_t status;
	prtd_pkg::run_word_t  res;
	prtd_pkg::run_word_t  run_q;
	logic                 run_valid_q;
	logic                 out_free;

	assign out_free  = !run_valid_q || run_ready;
	assign run_valid = run_valid_q;
	assign run       = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= prtd_pkg::DIM_W'(320);
			cfg_q.image_height <= prtd_pkg::DIM_W'(240);
			cfg_q.row_padding  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				prtd_pkg::REG_WIDTH:   cfg_q.image_width  <= wr_data;
				prtd_pkg::REG_HEIGHT:  cfg_q.image_height <= wr_data;
				prtd_pkg::REG_PADDING: cfg_q.row_padding  <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			run_valid_q <= 1'b1;
		end else if (run_ready) begin
			run_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			run_q <= res;
		end
	end

	prtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.out_free  (out_free),
		.status    (status),
		.cmd       (cmd)
	);

	prtd_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.src    (src),
		.cmd    (cmd),
		.status (status),
		.res    (res)
	);

endmodule
`default_nettype wire
